// File: rtl/fsr_pkg.sv
// Shared types and constants for the fan speed regulator.
// Holds field widths, register indexes, reset values, zone limits and the
// command and status structs that join the controller and the datapath.
package fsr_pkg;

    localparam int TEMP_W     = 12;
    localparam int DIST_W     = 13;
    localparam int GAIN_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int DELAY_W    = 17;
    localparam int DUTY_OUT_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 4;
    localparam int FRAC_W     = 8;
    localparam int STEP_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_RANGE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD_MS = 3'd5;

    localparam logic signed [TEMP_W-1:0] TARGET_RST = 12'sd800;
    localparam logic [GAIN_W-1:0]        ATTACK_RST = 8'd16;
    localparam logic [GAIN_W-1:0]        DECAY_RST  = 8'd8;
    localparam int                       RANGE_RST  = 400;
    localparam int                       FLOOR_RST  = 8;
    localparam logic [PERIOD_W-1:0]      PERIOD_RST = 16'd10000;

    localparam logic signed [DIST_W-1:0] DIST_ZERO   = 13'sd0;
    localparam logic signed [DIST_W-1:0] DIST_HOT    = 13'sd80;
    localparam logic signed [DIST_W-1:0] DIST_COLD   = -13'sd80;
    localparam logic signed [DIST_W-1:0] DIST_STOP   = -13'sd64;
    localparam logic signed [DIST_W-1:0] DIST_DBL_HI = 13'sd8;
    localparam logic signed [DIST_W-1:0] DIST_DBL_LO = -13'sd24;

    localparam logic [STEP_W-1:0] FRAC_0P7  = 13'd179;
    localparam logic [STEP_W-1:0] DISP_BIAS = 13'd16;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul1;
        logic mul2;
        logic upd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic out_room;
    } t_sts;

endpackage

// File: rtl/fsr_datapath.sv
// Datapath of the fan speed regulator: configuration registers, loop state,
// one shared multiplier, the speed update and the output register.
// Depends on fsr_pkg; sequenced by fsr_ctrl through t_cmd.
module fsr_datapath import fsr_pkg::*; #(
    parameter int DUTY_BITS  = 12,
    parameter int STOP_COUNT = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic signed [TEMP_W-1:0]     i_temperature,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [DUTY_OUT_W-1:0]        o_duty,
    output logic                         o_kick,
    output logic [DELAY_W-1:0]           o_next_delay_ms,
    output logic                         o_fan_stopped
);

    localparam int MA  = DUTY_BITS + FRAC_W;
    localparam int MP  = MA + STEP_W;
    localparam int SPW = MP + 4;

    logic signed [TEMP_W-1:0]   r_target;
    logic [GAIN_W-1:0]          r_attack;
    logic [GAIN_W-1:0]          r_decay;
    logic [DUTY_BITS-1:0]       r_range;
    logic [DUTY_BITS-1:0]       r_floor;
    logic [PERIOD_W-1:0]        r_period;

    logic signed [TEMP_W-1:0]   r_temp;
    logic signed [TEMP_W-1:0]   r_prev;
    logic [MA-1:0]              r_speed;
    logic [CNT_W-1:0]           r_count;
    logic                       r_stopped;
    logic [DUTY_BITS-1:0]       r_last;
    logic                       r_first;

    logic signed [DIST_W-1:0]   r_dist;
    logic signed [DIST_W-1:0]   r_disp;
    logic [MP-1:0]              r_prod;
    logic [MA-1:0]              r_spc;
    logic                       r_neg;

    logic                       r_out_valid;
    logic [DUTY_OUT_W-1:0]      r_duty;
    logic                       r_kick;
    logic [DELAY_W-1:0]         r_delay;
    logic                       r_stop_out;

    logic signed [TEMP_W-1:0]   prev_eff;
    logic signed [DIST_W-1:0]   n_dist;
    logic signed [DIST_W-1:0]   n_disp;
    logic                       cool, warm, hot, cold, disp_neg, disp_pos, hot_up;
    logic [MA-1:0]              mul_a;
    logic [STEP_W-1:0]          mul_b;
    logic [MP-1:0]              mul_p;
    logic signed [SPW-1:0]      sp_cur, prod_s, sp_new, sp_clamp, range_sp;
    logic signed [SPW-1:0]      atk40, dec16, dec32, dec64;
    logic                       at_floor, stop_hold, go_stop;
    logic [CNT_W-1:0]           cnt_base, n_count;
    logic [MA-1:0]              floor_sp, sp_fin, n_speed;
    logic [DUTY_BITS-1:0]       n_value;
    logic                       n_stopped, n_kick;
    logic [DELAY_W-1:0]         period_x1, period_x2, period_half, n_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_attack <= ATTACK_RST;
            r_decay  <= DECAY_RST;
            r_range  <= DUTY_BITS'(RANGE_RST);
            r_floor  <= DUTY_BITS'(FLOOR_RST);
            r_period <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TARGET_TEMP:    r_target <= signed'(i_cfg_data[TEMP_W-1:0]);
                CFG_ATTACK_GAIN:    r_attack <= i_cfg_data[GAIN_W-1:0];
                CFG_DECAY_GAIN:     r_decay  <= i_cfg_data[GAIN_W-1:0];
                CFG_DUTY_RANGE:     r_range  <= i_cfg_data[DUTY_BITS-1:0];
                CFG_DUTY_FLOOR:     r_floor  <= i_cfg_data[DUTY_BITS-1:0];
                CFG_POLL_PERIOD_MS: r_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prev_eff = r_first ? r_target : r_prev;
        n_dist   = DIST_W'(r_temp) - DIST_W'(r_target);
        n_disp   = DIST_W'(r_temp) - DIST_W'(prev_eff);

        cool     = r_dist < DIST_ZERO;
        warm     = r_dist > DIST_ZERO;
        hot      = r_dist > DIST_HOT;
        cold     = r_dist < DIST_COLD;
        disp_neg = r_disp[DIST_W-1];
        disp_pos = !disp_neg && (r_disp != DIST_ZERO);
        hot_up   = hot && !disp_neg;

        if (i_cmd.mul2) begin
            mul_a = r_prod[MA-1:0];
            mul_b = DISP_BIAS + $unsigned(r_disp);
        end else if (cold && disp_neg) begin
            mul_a = r_speed;
            mul_b = FRAC_0P7;
        end else if (hot_up) begin
            mul_a = MA'(r_floor);
            mul_b = STEP_W'(r_attack);
        end else begin
            mul_a = MA'(r_floor);
            mul_b = STEP_W'(r_decay);
        end
        mul_p = MP'(mul_a) * MP'(mul_b);
    end

    always_comb begin
        sp_cur   = signed'(SPW'(r_speed));
        prod_s   = signed'(SPW'(r_prod));
        range_sp = signed'(SPW'({r_range, {FRAC_W{1'b0}}}));
        atk40    = signed'(SPW'({r_attack, 5'b0}) + SPW'({r_attack, 3'b0}));
        dec16    = signed'(SPW'({r_decay, 4'b0}));
        dec32    = signed'(SPW'({r_decay, 5'b0}));
        dec64    = signed'(SPW'({r_decay, 6'b0}));
        floor_sp = {r_floor, {FRAC_W{1'b0}}};

        if (r_stopped && cool) begin
            sp_new = '0;
        end else if (r_stopped && warm) begin
            sp_new = signed'(SPW'(floor_sp));
        end else if (hot) begin
            sp_new = disp_neg ? sp_cur - (prod_s <<< 3) : sp_cur + (prod_s <<< 2);
        end else if (cold) begin
            sp_new = disp_neg ? (prod_s >>> FRAC_W) : sp_cur - (prod_s <<< 4);
        end else if (warm) begin
            if (disp_pos) begin
                sp_new = sp_cur + atk40;
            end else if (disp_neg) begin
                sp_new = sp_cur - dec16;
            end else begin
                sp_new = sp_cur;
            end
        end else if (cool) begin
            sp_new = disp_neg ? sp_cur - dec64 : sp_cur - dec32;
        end else begin
            sp_new = sp_cur;
        end
        sp_clamp = (sp_new > range_sp) ? range_sp : sp_new;
    end

    always_comb begin
        at_floor  = r_neg || (r_spc[MA-1:FRAC_W] <= r_floor);
        cnt_base  = (r_stopped && warm) ? '0 : r_count;
        if (!at_floor) begin
            n_count = '0;
        end else if (cnt_base == '1) begin
            n_count = cnt_base;
        end else begin
            n_count = cnt_base + CNT_W'(1);
        end
        sp_fin    = at_floor ? floor_sp : r_spc;
        stop_hold = n_count >= CNT_W'(STOP_COUNT);
        go_stop   = stop_hold && (r_dist < DIST_STOP);

        if (go_stop) begin
            n_value   = '0;
            n_speed   = '0;
            n_stopped = 1'b1;
            n_kick    = 1'b0;
        end else if (stop_hold) begin
            n_value   = r_last;
            n_speed   = sp_fin;
            n_stopped = r_stopped;
            n_kick    = 1'b0;
        end else begin
            n_value   = sp_fin[MA-1:FRAC_W];
            n_speed   = sp_fin;
            n_stopped = 1'b0;
            n_kick    = r_stopped;
        end

        period_x1   = DELAY_W'(r_period);
        period_x2   = {r_period, 1'b0};
        period_half = DELAY_W'(r_period[PERIOD_W-1:1]);
        if (r_stopped && cool) begin
            n_delay = period_x2;
        end else if (r_stopped && warm) begin
            n_delay = period_half;
        end else if ((r_dist < DIST_DBL_HI) && (r_dist > DIST_DBL_LO)) begin
            n_delay = period_x2;
        end else begin
            n_delay = period_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp <= i_temperature;
        end
        if (i_cmd.diff) begin
            r_dist <= n_dist;
            r_disp <= n_disp;
        end
        if (i_cmd.mul1 || (i_cmd.mul2 && hot_up)) begin
            r_prod <= mul_p;
        end
        if (i_cmd.upd) begin
            r_spc <= sp_clamp[MA-1:0];
            r_neg <= sp_clamp[SPW-1];
        end
        if (i_cmd.fin) begin
            r_duty     <= DUTY_OUT_W'(n_value);
            r_kick     <= n_kick;
            r_delay    <= n_delay;
            r_stop_out <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_speed     <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.diff) begin
                r_prev <= r_temp;
                if (r_first) begin
                    r_speed   <= floor_sp;
                    r_stopped <= 1'b0;
                    r_first   <= 1'b0;
                end
            end
            if (i_cmd.fin) begin
                r_speed   <= n_speed;
                r_count   <= n_count;
                r_stopped <= n_stopped;
                r_last    <= n_value;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_room  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_duty          = r_duty;
    assign o_kick          = r_kick;
    assign o_next_delay_ms = r_delay;
    assign o_fan_stopped   = r_stop_out;

endmodule

// File: rtl/fsr_ctrl.sv
// Controller of the fan speed regulator: steps one sample through the
// datapath (difference, two multiplies, speed update, finish).
// Depends on fsr_pkg for the command and status structs.
module fsr_ctrl import fsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_UPD;
            ST_UPD:  n_state = ST_FIN;
            ST_FIN:  if (i_sts.out_room) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.diff = (r_state == ST_DIFF);
    assign o_cmd.mul1 = (r_state == ST_MUL1);
    assign o_cmd.mul2 = (r_state == ST_MUL2);
    assign o_cmd.upd  = (r_state == ST_UPD);
    assign o_cmd.fin  = (r_state == ST_FIN) && i_sts.out_room;

endmodule

// File: rtl/fan_speed_regulator.sv
// Top level of the fan speed regulator.
// Instantiates fsr_ctrl and fsr_datapath; depends on fsr_pkg.
//
// Usage:
// The sample channel (i_valid, o_ready, i_temperature) takes one temperature
// beat per poll. The result channel (o_valid, i_ready) delivers one beat per
// sample with the duty, the restart kick, the next poll delay and whether the
// fan is now stopped. Registers are to be written by the user through i_cfg_wr_en,
// i_cfg_index and i_cfg_data only while no sample is in flight; the block itself
// does not enforce this. A new sample is accepted only once the previous one has
// reached its finish step; the controller steps each sample through a sequence
// around the single shared multiplier, which serves two steps.
// A result waits in the output register while the receiver stalls; the next
// sample is still accepted and runs up to its last step, which waits until
// the output register is free.
// Reset restores the register defaults, clears the loop state, marks the
// next sample as the first one and leaves no result pending.
module fan_speed_regulator import fsr_pkg::*; #(
    parameter int DUTY_BITS  = 12,
    parameter int STOP_COUNT = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DUTY_OUT_W-1:0]    o_duty,
    output logic                     o_kick,
    output logic [DELAY_W-1:0]       o_next_delay_ms,
    output logic                     o_fan_stopped,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    fsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fsr_datapath #(
        .DUTY_BITS  (DUTY_BITS),
        .STOP_COUNT (STOP_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_temperature   (i_temperature),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_duty          (o_duty),
        .o_kick          (o_kick),
        .o_next_delay_ms (o_next_delay_ms),
        .o_fan_stopped   (o_fan_stopped)
    );

endmodule

// File: rtl/fsr_checker.sv
// Port-level checks for the fan speed regulator, bound to its top level.
// Depends on fsr_pkg for field widths.
module fsr_checker import fsr_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [DUTY_OUT_W-1:0]    o_duty,
    input logic                     o_kick,
    input logic [DELAY_W-1:0]       o_next_delay_ms,
    input logic                     o_fan_stopped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_duty) && $stable(o_kick)
            && $stable(o_next_delay_ms) && $stable(o_fan_stopped))
        else $error("result beat changed while stalled");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fan_stopped |-> (o_duty == '0) && !o_kick)
        else $error("stopped fan reports nonzero duty or a kick");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second sample accepted while one is in flight");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared with no sample in flight");

endmodule

bind fan_speed_regulator fsr_checker u_fsr_checker (.*);
